FILE: rtl/mdlr_pkg.sv
// ----------------------------------------------------------------------------
// mdlr_pkg
// Shared constants and types of the mono downmix linear resampler.
// ----------------------------------------------------------------------------
package mdlr_pkg;

  // Channel inputs carried by every frame word.
  localparam int MAX_CHANNELS = 8;
  localparam int CH_CNT_BITS  = 4;

  // Defaults of the top level parameters.
  localparam int MAX_OUTPUTS_DEF = 64;
  localparam int FRAC_BITS_DEF   = 24;
  localparam int SAMPLE_BITS_DEF = 16;

  // Phase register width (unsigned Q7.24 at the default fraction width).
  localparam int PHASE_BITS = 31;

  // Phase step after reset, in whole input samples.
  localparam int PHASE_STEP_RESET_INT = 3;

  // Configuration register indexes.
  typedef enum logic {
    REG_CHANNEL_COUNT = 1'b0,
    REG_PHASE_STEP    = 1'b1
  } reg_index_t;

  // Word kinds.
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Requests from the front end to the interpolator.
  typedef struct packed {
    logic frame;   // downmixed sample is ready
    logic flush;   // end of stream
  } cmd_t;

  // Status from the interpolator to the front end.
  typedef struct packed {
    logic done;    // all results of the current word are in the output register
  } status_t;

endpackage

FILE: rtl/mdlr_lane.sv
// ----------------------------------------------------------------------------
// mdlr_lane
// One channel lane: capture the channel sample, zeroed when the channel is
// outside the active count.
// ----------------------------------------------------------------------------
module mdlr_lane #(
  parameter int SAMPLE_BITS = mdlr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic                          enable,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic signed [SAMPLE_BITS-1:0] lane_sample
);

  always_ff @(posedge clk) begin
    if (load) begin
      lane_sample <= enable ? sample : '0;
    end
  end

endmodule

FILE: rtl/mdlr_merge.sv
// ----------------------------------------------------------------------------
// mdlr_merge
// Merge the lanes: registered adder tree, then divide by the channel count
// through a reciprocal multiply with one correction step (truncate to zero).
// ----------------------------------------------------------------------------
module mdlr_merge #(
  parameter int SAMPLE_BITS = mdlr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic signed [SAMPLE_BITS-1:0]       lane_sample [mdlr_pkg::MAX_CHANNELS],
  input  logic [mdlr_pkg::CH_CNT_BITS-1:0]    count,
  output logic                                out_valid,
  output logic signed [SAMPLE_BITS-1:0]       mono
);

  localparam int SW  = SAMPLE_BITS + 3;   // sum of eight samples
  localparam int K   = SW;                // reciprocal scale
  localparam int EW  = SW + mdlr_pkg::CH_CNT_BITS;
  localparam int LAT = 6;

  localparam logic [K:0] RECIP [mdlr_pkg::MAX_CHANNELS] = '{
    (K+1)'((2**K) / 1), (K+1)'((2**K) / 2), (K+1)'((2**K) / 3), (K+1)'((2**K) / 4),
    (K+1)'((2**K) / 5), (K+1)'((2**K) / 6), (K+1)'((2**K) / 7), (K+1)'((2**K) / 8)
  };

  logic [LAT-1:0] vld;

  logic signed [SW-1:0] sum4 [4];
  logic signed [SW-1:0] sum;
  logic [mdlr_pkg::CH_CNT_BITS-1:0] n2, n3, n4, n5;
  logic                 neg3, neg4, neg5;
  logic [SW-1:0]        a3, a4, a5;
  logic [K:0]           recip3;
  logic [2*K:0]         prod4;
  logic [SW-1:0]        q0;
  logic [EW-1:0]        qn;
  logic [EW-1:0]        rem;
  logic [SW-1:0]        q;
  logic [SW-1:0]        q_signed;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // Tree: pairs, then the four partial sums.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      sum4[i] <= SW'(lane_sample[2*i]) + SW'(lane_sample[2*i+1]);
    end
    sum <= sum4[0] + sum4[1] + sum4[2] + sum4[3];
    n2  <= count;
  end

  // Divide: magnitude and reciprocal, product, quotient estimate, fix-up.
  always_ff @(posedge clk) begin
    neg3   <= sum[SW-1];
    a3     <= sum[SW-1] ? SW'(-sum) : SW'(sum);
    recip3 <= RECIP[3'(n2 - 1'b1)];
    n3     <= n2;

    prod4 <= (2*K+1)'(a3) * (2*K+1)'(recip3);
    a4    <= a3;
    n4    <= n3;
    neg4  <= neg3;

    q0   <= prod4[K +: SW];
    a5   <= a4;
    n5   <= n4;
    neg5 <= neg4;

    mono <= q_signed[SAMPLE_BITS-1:0];
  end

  always_comb begin
    qn       = EW'(q0) * EW'(n5);
    rem      = EW'(a5) - qn;
    q        = (rem >= EW'(n5)) ? q0 + 1'b1 : q0;
    q_signed = neg5 ? -q : q;
  end

  assign out_valid = vld[LAT-1];

  property p_latency;
    @(posedge clk) disable iff (rst) in_valid |-> ##(LAT) out_valid;
  endproperty
  a_latency: assert property (p_latency) else $error("merge latency broken");

endmodule

FILE: rtl/mdlr_interp.sv
// ----------------------------------------------------------------------------
// mdlr_interp
// Phase cursor and linear interpolation between the held and the new sample;
// owns the output register.
// ----------------------------------------------------------------------------
module mdlr_interp #(
  parameter int SAMPLE_BITS = mdlr_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = mdlr_pkg::FRAC_BITS_DEF,
  parameter int MAX_OUTPUTS = mdlr_pkg::MAX_OUTPUTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mdlr_pkg::cmd_t                      cmd,
  input  logic signed [SAMPLE_BITS-1:0]       mono,
  input  logic [mdlr_pkg::PHASE_BITS-1:0]     phase_step,
  output mdlr_pkg::status_t                   status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       out_sample,
  output logic                                last
);

  localparam int PB = mdlr_pkg::PHASE_BITS;
  localparam int CW = $clog2(MAX_OUTPUTS + 1);
  localparam int PW = SAMPLE_BITS + FRAC_BITS + 2;
  localparam logic [PB-1:0] ONE = PB'(1) << FRAC_BITS;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_ADD, S_FLUSH} state_t;

  state_t state;

  logic signed [SAMPLE_BITS-1:0] prev_sample;
  logic signed [SAMPLE_BITS-1:0] cur_sample;
  logic                          have_prev;
  logic [PB-1:0]                 cursor;
  logic [CW-1:0]                 count;
  logic                          last_pending;
  logic signed [PW-1:0]          prod;

  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [FRAC_BITS:0]     frac;
  logic [PB:0]                   cursor_sum;
  logic [PB-1:0]                 cursor_next;
  logic                          last_next;
  logic signed [PW-1:0]          prod_shift;
  logic signed [SAMPLE_BITS:0]   interp;
  logic [PB-1:0]                 cursor_drop;
  logic                          slot_free;
  logic                          emit;
  logic                          finish;

  always_comb begin
    diff        = (SAMPLE_BITS+1)'(cur_sample) - (SAMPLE_BITS+1)'(prev_sample);
    frac        = $signed({1'b0, cursor[FRAC_BITS-1:0]});
    cursor_sum  = {1'b0, cursor} + {1'b0, phase_step};
    cursor_next = cursor_sum[PB] ? {PB{1'b1}} : cursor_sum[PB-1:0];
    last_next   = (cursor_next >= ONE) || (count + 1'b1 == CW'(MAX_OUTPUTS));
    prod_shift  = prod >>> FRAC_BITS;
    interp      = (SAMPLE_BITS+1)'(prev_sample) + prod_shift[SAMPLE_BITS:0];
    cursor_drop = (cursor >= ONE) ? cursor - ONE : '0;
    slot_free   = !out_valid || out_ready;
    emit        = slot_free && ((state == S_ADD) || (state == S_FLUSH));
    // Word finished: no result due, or its final result goes out now.
    unique case (state)
      S_IDLE:  finish = cmd.flush ? !(have_prev && cursor < ONE)
                                  : (cmd.frame && (!have_prev || cursor >= ONE));
      S_ADD:   finish = slot_free && last_pending;
      S_FLUSH: finish = slot_free;
      default: finish = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      have_prev   <= 1'b0;
      cursor      <= '0;
      prev_sample <= '0;
      count       <= '0;
      out_valid   <= 1'b0;
      status.done <= 1'b0;
    end else begin
      status.done <= finish;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.flush) begin
            if (have_prev && cursor < ONE) begin
              state <= S_FLUSH;
            end else begin
              have_prev   <= 1'b0;
              cursor      <= '0;
              prev_sample <= '0;
            end
          end else if (cmd.frame) begin
            cur_sample <= mono;
            if (!have_prev) begin
              // first sample only primes the history
              prev_sample <= mono;
              have_prev   <= 1'b1;
            end else if (cursor >= ONE) begin
              cursor      <= cursor - ONE;
              prev_sample <= mono;
            end else begin
              count <= '0;
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod         <= PW'(diff) * PW'(frac);
          cursor       <= cursor_next;
          count        <= count + 1'b1;
          last_pending <= last_next;
          state        <= S_ADD;
        end
        S_ADD: begin
          if (slot_free) begin
            out_sample <= interp[SAMPLE_BITS-1:0];
            last       <= last_pending;
            if (last_pending) begin
              cursor      <= cursor_drop;
              prev_sample <= cur_sample;
              state       <= S_IDLE;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_FLUSH: begin
          if (slot_free) begin
            out_sample  <= prev_sample;
            last        <= 1'b1;
            have_prev   <= 1'b0;
            cursor      <= '0;
            prev_sample <= '0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  property p_mul_below_one;
    @(posedge clk) disable iff (rst) (state == S_MUL) |-> (cursor < ONE);
  endproperty
  a_mul_below_one: assert property (p_mul_below_one)
    else $error("interpolation with cursor at or above one");

  property p_count_bound;
    @(posedge clk) disable iff (rst) (state != S_IDLE) |-> (count <= CW'(MAX_OUTPUTS));
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("output count overrun");

endmodule

FILE: rtl/mono_downmix_linear_resampler.sv
// ----------------------------------------------------------------------------
// mono_downmix_linear_resampler
// Average up to eight channels to mono, then resample by linear interpolation
// under a fixed-point phase cursor.
// ----------------------------------------------------------------------------
//
//  channel  | signals                                   | moves
//  ---------+-------------------------------------------+-----------------------
//  input    | in_valid, in_ready, kind, sample_0..7     | one frame or flush word
//  output   | out_valid, out_ready, out_sample, last    | one mono sample word
//  config   | cfg_write, cfg_index, cfg_data            | one register write
//
//  A frame word is captured by the lanes at its accept edge, then passes the
//  merge adder tree and divider before it reaches the interpolator; each result
//  then takes a cursor multiply and then the add into the output register, and
//  the add waits while the output is stalled. The next word is taken once the
//  interpolator reports the word done; a flush word may hand out one result.
//  One word is worked on at a time.
//  Reset (rst, synchronous) clears the history, cursor and registers to their
//  defaults; no clearing pass follows.
//  A stalled output holds the result register; the next input word can be
//  taken while the final result of the previous one still waits.
//
module mono_downmix_linear_resampler #(
  parameter int MAX_OUTPUTS = mdlr_pkg::MAX_OUTPUTS_DEF,
  parameter int FRAC_BITS   = mdlr_pkg::FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = mdlr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [mdlr_pkg::PHASE_BITS-1:0]     cfg_data,
  // input words
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                kind,
  input  logic signed [SAMPLE_BITS-1:0]       sample_0,
  input  logic signed [SAMPLE_BITS-1:0]       sample_1,
  input  logic signed [SAMPLE_BITS-1:0]       sample_2,
  input  logic signed [SAMPLE_BITS-1:0]       sample_3,
  input  logic signed [SAMPLE_BITS-1:0]       sample_4,
  input  logic signed [SAMPLE_BITS-1:0]       sample_5,
  input  logic signed [SAMPLE_BITS-1:0]       sample_6,
  input  logic signed [SAMPLE_BITS-1:0]       sample_7,
  // output words
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       out_sample,
  output logic                                last
);

  localparam int NCH = mdlr_pkg::MAX_CHANNELS;
  localparam int CB  = mdlr_pkg::CH_CNT_BITS;
  localparam int PB  = mdlr_pkg::PHASE_BITS;

  typedef enum logic {T_IDLE, T_BUSY} state_t;

  state_t state;

  logic [CB-1:0] channel_count;
  logic [PB-1:0] phase_step;
  logic [CB-1:0] n_eff;

  logic                          accept;
  logic                          mix_start;
  logic                          flush_req;
  logic signed [SAMPLE_BITS-1:0] samples     [NCH];
  logic signed [SAMPLE_BITS-1:0] lane_sample [NCH];
  logic                          mono_valid;
  logic signed [SAMPLE_BITS-1:0] mono;
  mdlr_pkg::cmd_t                cmd;
  mdlr_pkg::status_t             status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CB'(1);
      phase_step    <= PB'(mdlr_pkg::PHASE_STEP_RESET_INT) << FRAC_BITS;
    end else if (cfg_write) begin
      unique case (mdlr_pkg::reg_index_t'(cfg_index))
        mdlr_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data[CB-1:0];
        mdlr_pkg::REG_PHASE_STEP:    phase_step    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Zero acts as one channel; anything above the lane count as all lanes.
  always_comb begin
    priority if (channel_count == '0) begin
      n_eff = CB'(1);
    end else if (channel_count > CB'(NCH)) begin
      n_eff = CB'(NCH);
    end else begin
      n_eff = channel_count;
    end
  end

  assign samples[0] = sample_0;
  assign samples[1] = sample_1;
  assign samples[2] = sample_2;
  assign samples[3] = sample_3;
  assign samples[4] = sample_4;
  assign samples[5] = sample_5;
  assign samples[6] = sample_6;
  assign samples[7] = sample_7;

  // Take one word at a time; hold off until the interpolator reports done.
  assign in_ready = (state == T_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      mix_start <= 1'b0;
      flush_req <= 1'b0;
    end else begin
      mix_start <= accept && (kind == mdlr_pkg::KIND_FRAME);
      flush_req <= accept && (kind == mdlr_pkg::KIND_FLUSH);
      unique case (state)
        T_IDLE: if (accept) state <= T_BUSY;
        T_BUSY: if (status.done) state <= T_IDLE;
        default: state <= T_IDLE;
      endcase
    end
  end

  for (genvar i = 0; i < NCH; i++) begin : g_lane
    mdlr_lane #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane (
      .clk        (clk),
      .load       (accept),
      .enable     (CB'(i) < n_eff),
      .sample     (samples[i]),
      .lane_sample(lane_sample[i])
    );
  end

  mdlr_merge #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (mix_start),
    .lane_sample(lane_sample),
    .count      (n_eff),
    .out_valid  (mono_valid),
    .mono       (mono)
  );

  assign cmd.frame = mono_valid;
  assign cmd.flush = flush_req;

  mdlr_interp #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .MAX_OUTPUTS(MAX_OUTPUTS)
  ) u_interp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .mono      (mono),
    .phase_step(phase_step),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_sample(out_sample),
    .last      (last)
  );

  property p_one_at_a_time;
    @(posedge clk) disable iff (rst) accept |=> !in_ready;
  endproperty
  a_one_at_a_time: assert property (p_one_at_a_time) else $error("second word taken");

  property p_done_when_busy;
    @(posedge clk) disable iff (rst) status.done |-> (state == T_BUSY);
  endproperty
  a_done_when_busy: assert property (p_done_when_busy) else $error("done without word");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mono downmix linear resampler. A short table of
// directed words covers the extremes, flushes and out-of-range settings. It is
// followed by random phases under several register settings. Every result word
// is checked against a bit-true model of the downmix and interpolation, or against the values typed into a row.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int SW      = mdlr_pkg::SAMPLE_BITS_DEF;
  localparam int FRAC    = mdlr_pkg::FRAC_BITS_DEF;
  localparam int MAX_OUT = mdlr_pkg::MAX_OUTPUTS_DEF;
  localparam int NCH     = mdlr_pkg::MAX_CHANNELS;
  localparam int PB      = mdlr_pkg::PHASE_BITS;
  localparam int CB      = mdlr_pkg::CH_CNT_BITS;

  localparam logic [PB-1:0] PHASE_ONE  = {{(PB-1){1'b0}}, 1'b1} << FRAC;
  localparam logic [PB-1:0] CURSOR_MAX = '1;
  localparam logic [PB-1:0] STEP_RESET = mdlr_pkg::PHASE_STEP_RESET_INT << FRAC;
  localparam logic [PB-1:0] STEP_MIN   = 31'h0004_0000;   // 1/64
  localparam logic [PB-1:0] STEP_MAX   = 31'h4000_0000;   // 64.0

  localparam int LIMIT      = 1_000_000;      // cycles before the run is called hung
  localparam int HOLD_CYC   = 400;            // long receiver hold-off
  localparam int SETTLE_CYC = 32;             // covers a frame word with no result
  localparam int TAIL_CYC   = 2 * MAX_OUT + 16;
  localparam int PEND_DEPTH = 256;            // ring of expected result words
  localparam int DIR_DEPTH  = 48;             // rows of the directed table

  typedef logic [NCH-1:0][SW-1:0] frame_t;

  typedef struct {
    logic [SW-1:0] smp;
    logic          last;
  } out_word_t;

  typedef enum {ROW_WORD, ROW_REG} row_op_t;

  // One line of the directed table: either an input word or a register write.
  // typed_n >= 0 means the expected results are written into the row itself.
  typedef struct {
    row_op_t                 op;
    logic                    kind;
    frame_t                  smp;
    mdlr_pkg::reg_index_t    ridx;
    logic [PB-1:0]           rval;
    int                      typed_n;
    logic [SW-1:0]           typed_s;
    logic                    typed_l;
  } dir_row_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #2 clk = ~clk;

  // DUT inputs, all known from time zero
  logic                  cfg_write = 1'b0;
  logic                  cfg_index = mdlr_pkg::REG_CHANNEL_COUNT;
  logic [PB-1:0]         cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  kind      = mdlr_pkg::KIND_FRAME;
  frame_t                smp_bus   = '0;
  logic                  out_ready = 1'b0;

  // DUT outputs
  logic                  in_ready;
  logic                  out_valid;
  logic signed [SW-1:0]  out_sample;
  logic                  last;

  // Resampler model state; it starts at the reset defaults and is never reset again
  logic [CB-1:0]          chan_cfg  = 4'd1;
  logic [PB-1:0]          step_cfg  = STEP_RESET;
  logic signed [SW-1:0]   hist_smp  = '0;
  logic                   hist_ok   = 1'b0;
  logic [PB-1:0]          phase_pos = '0;
  logic [SW-1:0]          pred_val [MAX_OUT];

  out_word_t   pend_buf [PEND_DEPTH];
  int unsigned pend_wr = 0;
  int unsigned pend_rd = 0;
  dir_row_t    dir_tab [DIR_DEPTH];
  int          dir_n = 0;

  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          calm     = 1'b0;   // both sides run with no idling
  bit          hold_req = 1'b0;   // ask the receiver for its long hold-off

  mono_downmix_linear_resampler DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .sample_0   (smp_bus[0]),
    .sample_1   (smp_bus[1]),
    .sample_2   (smp_bus[2]),
    .sample_3   (smp_bus[3]),
    .sample_4   (smp_bus[4]),
    .sample_5   (smp_bus[5]),
    .sample_6   (smp_bus[6]),
    .sample_7   (smp_bus[7]),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample),
    .last       (last)
  );

  // --------------------------------------------------------------------------
  // Model: downmix one word, then emit interpolated samples while the phase
  // cursor sits below one. Results land in pred_val; the count is returned.
  // --------------------------------------------------------------------------
  function automatic int resample_word(input logic k, input frame_t f);
    int                  n;
    int                  sum;
    int                  cnt;
    logic signed [SW-1:0] cur;
    longint              diff;
    longint              v;
    longint              nxt;
    cnt = 0;
    if (k == mdlr_pkg::KIND_FLUSH) begin
      // Flush: hand out the held sample only if its slot is still due, then clear.
      if (hist_ok && phase_pos < PHASE_ONE) begin
        pred_val[0] = hist_smp;
        cnt = 1;
      end
      hist_smp  = '0;
      hist_ok   = 1'b0;
      phase_pos = '0;
      return cnt;
    end
    // Clamp the channel count: zero acts as one, above eight acts as eight.
    if (chan_cfg == 0)
      n = 1;
    else if (chan_cfg > NCH)
      n = NCH;
    else
      n = chan_cfg;
    sum = 0;
    for (int c = 0; c < n; c++)
      sum += $signed(f[c]);
    cur = SW'(sum / n);   // int division truncates toward zero
    // First sample of a stream is only held.
    if (!hist_ok) begin
      hist_smp = cur;
      hist_ok  = 1'b1;
      return 0;
    end
    while (phase_pos < PHASE_ONE && cnt < MAX_OUT) begin
      diff = longint'(cur) - longint'(hist_smp);
      v    = longint'(hist_smp) + ((diff * longint'(phase_pos)) >>> FRAC);
      pred_val[cnt] = v[SW-1:0];
      cnt++;
      // Saturate the advance at the top of the cursor range.
      nxt = longint'(phase_pos) + longint'(step_cfg);
      phase_pos = (nxt > longint'(CURSOR_MAX)) ? CURSOR_MAX : nxt[PB-1:0];
    end
    // Drop one input sample; saturate at zero when the cursor never got past one.
    phase_pos = (phase_pos >= PHASE_ONE) ? phase_pos - PHASE_ONE : '0;
    hist_smp  = cur;
    return cnt;
  endfunction

  // Extremes and small values four times in ten, fully random bits the rest of the time.
  function automatic logic [SW-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return {1'b1, {(SW-1){1'b0}}};
      1:       return {1'b0, {(SW-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return SW'($urandom);
    endcase
  endfunction

  // Channel 0 carries v; the rest carry a pattern that must not matter at count 1.
  function automatic frame_t ch0_frame(input logic [SW-1:0] v);
    return {{(NCH-1){16'hA5A5}}, v};
  endfunction

  function automatic void add_word(input logic k, input frame_t f, input int tn,
                                   input logic [SW-1:0] ts, input logic tl);
    dir_tab[dir_n] = '{ROW_WORD, k, f, mdlr_pkg::REG_CHANNEL_COUNT, '0, tn, ts, tl};
    dir_n++;
  endfunction

  function automatic void add_reg(input mdlr_pkg::reg_index_t idx, input logic [PB-1:0] val);
    dir_tab[dir_n] = '{ROW_REG, mdlr_pkg::KIND_FRAME, '0, idx, val, -1, '0, 1'b0};
    dir_n++;
  endfunction

  // Log one expected result word.
  function automatic void pend_put(input logic [SW-1:0] s, input logic l);
    pend_buf[pend_wr % PEND_DEPTH] = '{smp: s, last: l};
    pend_wr++;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side. All calls start right after a falling edge.
  // --------------------------------------------------------------------------

  // Write one register; only called while the block is idle.
  task automatic set_reg(input mdlr_pkg::reg_index_t idx, input logic [PB-1:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    if (idx == mdlr_pkg::REG_CHANNEL_COUNT)
      chan_cfg = val[CB-1:0];
    else
      step_cfg = val;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Offer one word, hold it until taken, then log what it should produce.
  task automatic offer_word(input logic k, input frame_t f, input int tn,
                            input logic [SW-1:0] ts, input logic tl);
    int n;
    // Idle at random before the word goes out.
    while (!calm && $urandom_range(99) < 31) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    kind     = k;
    smp_bus  = f;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    // Word accepted at this edge: advance the model even for typed rows.
    n = resample_word(k, f);
    if (tn < 0) begin
      for (int i = 0; i < n; i++)
        pend_put(pred_val[i], (i == n - 1));
    end else begin
      for (int i = 0; i < tn; i++)
        pend_put(ts, tl);
    end
    @(negedge clk);
  endtask

  // Drop valid, wait for every pending result, then give a word with no
  // result time to leave the pipeline.
  task automatic settle();
    in_valid = 1'b0;
    while (pend_wr != pend_rd)
      @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // One random phase under one setting. Junk in the upper data bits of the
  // channel count write must be dropped by the block.
  task automatic run_phase(input logic [CB-1:0] ch, input logic [PB-1:0] step,
                           input int items, input int flush_pct, input bit stall);
    frame_t f;
    logic   k;
    settle();
    set_reg(mdlr_pkg::REG_CHANNEL_COUNT, {(PB-CB)'($urandom), ch});
    set_reg(mdlr_pkg::REG_PHASE_STEP, step);
    if (stall)
      hold_req = 1'b1;
    for (int i = 0; i < items; i++) begin
      k = ($urandom_range(99) < flush_pct) ? mdlr_pkg::KIND_FLUSH : mdlr_pkg::KIND_FRAME;
      for (int c = 0; c < NCH; c++)
        f[c] = pick_sample();
      offer_word(k, f, -1, '0, 1'b0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: random ready, one long hold-off on request.
  // --------------------------------------------------------------------------
  initial begin : rx_side
    int hold_left;
    bit held_once;
    hold_left = 0;
    held_once = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held_once) begin
        held_once = 1'b1;
        hold_left = HOLD_CYC;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = calm || ($urandom_range(99) >= 31);
      end
    end
  end

  // Compare every accepted result word with the oldest pending one.
  always @(posedge clk) begin : rx_check
    out_word_t w;
    if (!rst && out_valid && out_ready) begin
      if (pend_wr == pend_rd) begin
        $error("out word with nothing pending: out_sample %0d last %0b", out_sample, last);
        errors++;
      end else begin
        w = pend_buf[pend_rd % PEND_DEPTH];
        pend_rd++;
        if (out_sample !== w.smp) begin
          $error("out_sample: expected %0d, got %0d", $signed(w.smp), out_sample);
          errors++;
        end
        if (last !== w.last) begin
          $error("last: expected %0b, got %0b", w.last, last);
          errors++;
        end
      end
    end
  end

  // Hang guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table, starting from the reset defaults (one channel, step 3.0).
    add_word(mdlr_pkg::KIND_FRAME, ch0_frame(16'd1000), 0, '0, 1'b0);   // first: held only
    add_word(mdlr_pkg::KIND_FLUSH, {8{16'h7FFF}}, 1, 16'd1000, 1'b1);   // held sample out
    add_word(mdlr_pkg::KIND_FLUSH, {8{16'h8000}}, 0, '0, 1'b0);         // nothing held
    add_word(mdlr_pkg::KIND_FRAME, ch0_frame(16'h7FFF), 0, '0, 1'b0);
    add_word(mdlr_pkg::KIND_FRAME, ch0_frame(16'h8000), 1, 16'h7FFF, 1'b1); // full swing
    add_word(mdlr_pkg::KIND_FRAME, ch0_frame(16'h0000), 0, '0, 1'b0);   // cursor at 2.0
    add_word(mdlr_pkg::KIND_FRAME, ch0_frame(16'd5), 0, '0, 1'b0);      // cursor exactly 1.0
    add_word(mdlr_pkg::KIND_FRAME, ch0_frame(16'd100), 1, 16'd5, 1'b1);
    add_word(mdlr_pkg::KIND_FLUSH, '0, 0, '0, 1'b0);                    // held slot not due
    add_reg(mdlr_pkg::REG_CHANNEL_COUNT, 31'd8);
    add_word(mdlr_pkg::KIND_FRAME, {8{16'h7FFF}}, 0, '0, 1'b0);
    add_word(mdlr_pkg::KIND_FRAME, {8{16'h8000}}, 1, 16'h7FFF, 1'b1);
    add_word(mdlr_pkg::KIND_FRAME, {4{16'h7FFF, 16'h8000}}, 0, '0, 1'b0); // -4/8 gives 0
    add_reg(mdlr_pkg::REG_PHASE_STEP, STEP_MIN);
    add_word(mdlr_pkg::KIND_FRAME, {16'h0007, 16'hFFF9, 16'h1234, 16'hEDCC,
                                    16'h0001, 16'hFFFF, 16'h4000, 16'hC000}, -1, '0, 1'b0);
    add_word(mdlr_pkg::KIND_FRAME, {8{16'h7FFF}}, -1, '0, 1'b0);        // full output burst
    add_word(mdlr_pkg::KIND_FRAME, {8{16'h8000}}, -1, '0, 1'b0);
    add_reg(mdlr_pkg::REG_CHANNEL_COUNT, 31'd0);                        // zero acts as one
    add_word(mdlr_pkg::KIND_FRAME, ch0_frame(16'hC000), -1, '0, 1'b0);
    add_reg(mdlr_pkg::REG_CHANNEL_COUNT, 31'd15);                       // above eight: eight
    add_word(mdlr_pkg::KIND_FRAME, {{7{16'hFFFF}}, 16'h0000}, -1, '0, 1'b0);
    add_reg(mdlr_pkg::REG_PHASE_STEP, '0);                              // limit, cursor floor
    add_word(mdlr_pkg::KIND_FRAME, {8{16'h7FFF}}, -1, '0, 1'b0);
    add_word(mdlr_pkg::KIND_FLUSH, {8{16'h8000}}, -1, '0, 1'b0);
    add_reg(mdlr_pkg::REG_PHASE_STEP, CURSOR_MAX);
    add_word(mdlr_pkg::KIND_FRAME, {8{16'h8000}}, 0, '0, 1'b0);
    add_word(mdlr_pkg::KIND_FRAME, {8{16'h7FFF}}, 1, 16'h8000, 1'b1);
    add_word(mdlr_pkg::KIND_FLUSH, '0, 0, '0, 1'b0);
    add_reg(mdlr_pkg::REG_PHASE_STEP, STEP_MAX);
    add_reg(mdlr_pkg::REG_CHANNEL_COUNT, 31'd3);
    add_word(mdlr_pkg::KIND_FRAME, {{5{16'h1111}}, 16'h7FFF, 16'h7FFF, 16'h7FFE},
             -1, '0, 1'b0);
    add_word(mdlr_pkg::KIND_FRAME, {{5{16'h2222}}, 16'h8000, 16'h8000, 16'h8001},
             -1, '0, 1'b0);
    add_word(mdlr_pkg::KIND_FRAME, {{5{16'h3333}}, 16'h0100, 16'hFF00, 16'h0001},
             -1, '0, 1'b0);

    for (int r = 0; r < dir_n; r++) begin
      if (dir_tab[r].op == ROW_REG) begin
        settle();
        set_reg(dir_tab[r].ridx, dir_tab[r].rval);
      end else begin
        offer_word(dir_tab[r].kind, dir_tab[r].smp, dir_tab[r].typed_n,
                   dir_tab[r].typed_s, dir_tab[r].typed_l);
      end
    end

    // Random phases: mostly frame runs with the odd flush.
    run_phase(4'd2, STEP_RESET, 40, 8, 1'b0);
    run_phase(4'd8, STEP_MIN, 12, 10, 1'b0);                       // bursts of full length
    run_phase(4'd1, STEP_MAX, 30, 5, 1'b0);
    calm = 1'b1;                                                   // no idling on either side
    run_phase(4'd5, PB'($urandom_range(32'h0004_0000, 32'h0200_0000)), 70, 8, 1'b0);
    calm = 1'b0;
    run_phase(4'd0, 31'h00C0_0000, 50, 8, 1'b0);
    // Long frame run at the largest step walks the cursor into saturation.
    run_phase(4'hF, CURSOR_MAX, 120, 0, 1'b0);
    // Receiver holds off while words keep coming, so the input side backs up.
    run_phase(CB'($urandom_range(1, 8)),
              PB'($urandom_range(32'h0010_0000, 32'h0400_0000)), 60, 8, 1'b1);
    run_phase(4'd3, '0, 6, 30, 1'b0);                              // step zero

    in_valid = 1'b0;
    while (pend_wr != pend_rd)
      @(negedge clk);
    repeat (TAIL_CYC) @(negedge clk);

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/mdlr_pkg.sv
rtl/mdlr_lane.sv
rtl/mdlr_merge.sv
rtl/mdlr_interp.sv
rtl/mono_downmix_linear_resampler.sv
tb/tb_top.sv
